// ===== src/ttlh_pkg.sv =====
package ttlh_pkg;

    localparam int FINE_BUCKETS   = 1024;
    localparam int COARSE_BUCKETS = 1024;
    localparam int COARSE_STEP_LG = 6;
    localparam int COARSE_STEP    = 1 << COARSE_STEP_LG;

    localparam int MAX_BINS = (FINE_BUCKETS > COARSE_BUCKETS) ? FINE_BUCKETS : COARSE_BUCKETS;
    localparam int IDX_W    = $clog2(MAX_BINS);
    localparam int FINE_W   = $clog2(FINE_BUCKETS);
    localparam int COARSE_W = $clog2(COARSE_BUCKETS);

    localparam int LAT_W  = 32;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 64;
    localparam int FRAC_W = 16;
    localparam int PCT_W  = 17;
    localparam int RUN_W  = CNT_W + $clog2(FINE_BUCKETS + COARSE_BUCKETS);

    localparam longint COARSE_SPAN = longint'(COARSE_BUCKETS) * longint'(COARSE_STEP);
    localparam longint COARSE_END  = longint'(FINE_BUCKETS) + COARSE_SPAN;

    // item function codes
    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic             wr;
        logic             coarse;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] wdata;
    } t_bin_req;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] res;
        res = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
        return res;
    endfunction

endpackage

// ===== src/ttlh_if.sv =====
interface ttlh_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [ttlh_pkg::LAT_W-1:0]  lat_us;
    logic [ttlh_pkg::FRAC_W-1:0] pct_frac;

    modport source (output valid, output func, output lat_us, output pct_frac,
                    input ready);
    modport sink (input valid, input func, input lat_us, input pct_frac,
                  output ready);
endinterface

interface ttlh_out_if;
    logic                       valid;
    logic                       ready;
    logic [ttlh_pkg::PCT_W-1:0] percentile_us;
    logic [ttlh_pkg::CNT_W-1:0] sample_total;
    logic [ttlh_pkg::SUM_W-1:0] latency_total;
    logic [ttlh_pkg::CNT_W-1:0] overflow_total;

    modport source (output valid, output percentile_us, output sample_total,
                    output latency_total, output overflow_total, input ready);
    modport sink (input valid, input percentile_us, input sample_total,
                  input latency_total, input overflow_total, output ready);
endinterface

// ===== src/ttlh_bin_store.sv =====
module ttlh_bin_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ttlh_pkg::t_bin_req         i_req,
    output logic [ttlh_pkg::CNT_W-1:0] o_rdata,
    output logic                       o_busy
);

    logic [ttlh_pkg::CNT_W-1:0] r_fine_mem   [ttlh_pkg::FINE_BUCKETS];
    logic [ttlh_pkg::CNT_W-1:0] r_coarse_mem [ttlh_pkg::COARSE_BUCKETS];

    logic [ttlh_pkg::IDX_W:0]    r_clr_cnt;
    logic [ttlh_pkg::IDX_W:0]    n_clr_cnt;
    logic [ttlh_pkg::IDX_W-1:0]  w_clr_idx;
    logic [ttlh_pkg::CNT_W-1:0]  r_fine_q;
    logic [ttlh_pkg::CNT_W-1:0]  r_coarse_q;
    logic                        r_sel_coarse;
    logic [ttlh_pkg::FINE_W-1:0]   w_fine_addr;
    logic [ttlh_pkg::COARSE_W-1:0] w_coarse_addr;

    assign o_busy        = (r_clr_cnt < (ttlh_pkg::IDX_W + 1)'(ttlh_pkg::MAX_BINS));
    assign w_clr_idx     = r_clr_cnt[ttlh_pkg::IDX_W-1:0];
    assign n_clr_cnt     = o_busy ? r_clr_cnt + (ttlh_pkg::IDX_W + 1)'(1) : r_clr_cnt;
    assign w_fine_addr   = o_busy ? w_clr_idx[ttlh_pkg::FINE_W-1:0]
                                  : i_req.idx[ttlh_pkg::FINE_W-1:0];
    assign w_coarse_addr = o_busy ? w_clr_idx[ttlh_pkg::COARSE_W-1:0]
                                  : i_req.idx[ttlh_pkg::COARSE_W-1:0];
    assign o_rdata       = r_sel_coarse ? r_coarse_q : r_fine_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else begin
            r_clr_cnt <= n_clr_cnt;
        end
    end

    // Sweep zeros through both tiers after reset, then serve one access a cycle
    always_ff @(posedge i_clk) begin
        if (o_busy) begin
            if (w_clr_idx < ttlh_pkg::IDX_W'(ttlh_pkg::FINE_BUCKETS) ||
                ttlh_pkg::FINE_BUCKETS == ttlh_pkg::MAX_BINS) begin
                r_fine_mem[w_fine_addr] <= '0;
            end
            if (w_clr_idx < ttlh_pkg::IDX_W'(ttlh_pkg::COARSE_BUCKETS) ||
                ttlh_pkg::COARSE_BUCKETS == ttlh_pkg::MAX_BINS) begin
                r_coarse_mem[w_coarse_addr] <= '0;
            end
        end else if (i_req.wr) begin
            if (i_req.coarse) begin
                r_coarse_mem[w_coarse_addr] <= i_req.wdata;
            end else begin
                r_fine_mem[w_fine_addr] <= i_req.wdata;
            end
        end
        r_fine_q     <= r_fine_mem[w_fine_addr];
        r_coarse_q   <= r_coarse_mem[w_coarse_addr];
        r_sel_coarse <= i_req.coarse;
    end

endmodule

// ===== src/two_tier_latency_histogram_top.sv =====
// Latency histogram with a fine tier of 1 us bins and a coarse tier of wide bins.
// Input channel i_item: func 0 records lat_us (count, sum, one bin or the
// overflow counter); func 1 asks for the percentile pct_frac (Q0.16) and yields
// one item on o_result with the bin bound and the three totals.
// Records: a bin read, then a write back of the incremented count in ST_REC;
// a latency beyond the coarse range bumps the overflow counter instead of a bin.
// Queries: the walk streams the bins, fine tier first, through the single read port of the bin
// store, one bin per cycle, and stops at the first bin whose running count
// passes the target; the result then goes through ST_DONE into the output
// register, and the next item is taken once the state is back in ST_IDLE.
// An empty histogram skips the walk and goes straight to ST_DONE.
// i_item.ready is low while a record or a walk is in progress or a result waits in ST_DONE.
// Reset: a clearing sweep zeroes the bins; ready stays low in ST_CLEAR until
// the sweep has finished after reset is released.
// Output stall: a result waits in the output register; records keep flowing,
// and a later query finishes its walk and holds until the register frees up.
module two_tier_latency_histogram_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ttlh_in_if.sink            i_item,
    ttlh_out_if.source         o_result
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_REC   = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int IDX_W = ttlh_pkg::IDX_W;
    localparam int CNT_W = ttlh_pkg::CNT_W;
    localparam int RUN_W = ttlh_pkg::RUN_W;
    localparam int PCT_W = ttlh_pkg::PCT_W;
    localparam int SUM_W = ttlh_pkg::SUM_W;
    localparam int LAT_W = ttlh_pkg::LAT_W;
    localparam int PROD_W = CNT_W + ttlh_pkg::FRAC_W;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_sample_count, n_sample_count;
    logic [SUM_W-1:0] r_latency_sum, n_latency_sum;
    logic [CNT_W-1:0] r_overflow_count, n_overflow_count;
    logic             r_rec_coarse, n_rec_coarse;
    logic [IDX_W-1:0] r_rec_idx, n_rec_idx;
    logic [CNT_W-1:0] r_target, n_target;
    logic [RUN_W-1:0] r_run, n_run;
    logic [IDX_W-1:0] r_iss_idx, n_iss_idx;
    logic             r_iss_coarse, n_iss_coarse;
    logic             r_iss_done, n_iss_done;
    logic             r_pend_valid, n_pend_valid;
    logic             r_pend_coarse, n_pend_coarse;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic [PCT_W-1:0] r_pct, n_pct;
    logic             r_out_valid, n_out_valid;
    logic [PCT_W-1:0] r_out_pct, n_out_pct;
    logic [CNT_W-1:0] r_out_sample, n_out_sample;
    logic [SUM_W-1:0] r_out_sum, n_out_sum;
    logic [CNT_W-1:0] r_out_ovf, n_out_ovf;

    ttlh_pkg::t_bin_req w_req;
    logic [CNT_W-1:0]   w_rdata;
    logic               w_clr_busy;

    logic             w_in_fire;
    logic [LAT_W-1:0] w_diff;
    logic             w_is_fine;
    logic             w_is_coarse;
    logic [RUN_W-1:0] w_run_sum;
    logic             w_hit;
    logic             w_last;
    logic [31:0]      w_coarse_bound;
    logic [PROD_W-1:0] w_product;

    ttlh_bin_store u_bins (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_rdata),
        .o_busy  (w_clr_busy)
    );

    assign i_item.ready            = (r_state == ST_IDLE);
    assign w_in_fire               = i_item.valid && i_item.ready;
    assign o_result.valid          = r_out_valid;
    assign o_result.percentile_us  = r_out_pct;
    assign o_result.sample_total   = r_out_sample;
    assign o_result.latency_total  = r_out_sum;
    assign o_result.overflow_total = r_out_ovf;

    assign w_diff      = i_item.lat_us - LAT_W'(ttlh_pkg::FINE_BUCKETS);
    assign w_is_fine   = (i_item.lat_us < LAT_W'(ttlh_pkg::FINE_BUCKETS));
    assign w_is_coarse = !w_is_fine && ({1'b0, w_diff} < (LAT_W + 1)'(ttlh_pkg::COARSE_SPAN));

    assign w_product = PROD_W'(r_sample_count) * PROD_W'(i_item.pct_frac);
    assign w_run_sum = r_run + RUN_W'(w_rdata);
    assign w_hit     = r_pend_valid && (w_run_sum > RUN_W'(r_target));
    assign w_last    = r_pend_coarse && (r_pend_idx == IDX_W'(ttlh_pkg::COARSE_BUCKETS - 1));
    assign w_coarse_bound = 32'(ttlh_pkg::FINE_BUCKETS) +
                            (32'(r_pend_idx) << ttlh_pkg::COARSE_STEP_LG);

    always_comb begin
        n_state          = r_state;
        n_sample_count   = r_sample_count;
        n_latency_sum    = r_latency_sum;
        n_overflow_count = r_overflow_count;
        n_rec_coarse     = r_rec_coarse;
        n_rec_idx        = r_rec_idx;
        n_target         = r_target;
        n_run            = r_run;
        n_iss_idx        = r_iss_idx;
        n_iss_coarse     = r_iss_coarse;
        n_iss_done       = r_iss_done;
        n_pend_valid     = 1'b0;
        n_pend_coarse    = r_iss_coarse;
        n_pend_idx       = r_iss_idx;
        n_pct            = r_pct;
        n_out_valid      = r_out_valid && !o_result.ready;
        n_out_pct        = r_out_pct;
        n_out_sample     = r_out_sample;
        n_out_sum        = r_out_sum;
        n_out_ovf        = r_out_ovf;
        w_req            = '0;

        unique case (r_state)
            ST_CLEAR: begin
                if (!w_clr_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_fire && i_item.func == ttlh_pkg::FUNC_RECORD) begin
                    n_sample_count = ttlh_pkg::sat_inc(r_sample_count);
                    n_latency_sum  = r_latency_sum + SUM_W'(i_item.lat_us);
                    n_rec_coarse   = !w_is_fine;
                    n_rec_idx      = w_is_fine ? IDX_W'(i_item.lat_us)
                                               : IDX_W'(w_diff >> ttlh_pkg::COARSE_STEP_LG);
                    w_req.coarse   = !w_is_fine;
                    w_req.idx      = n_rec_idx;
                    if (w_is_fine || w_is_coarse) begin
                        n_state = ST_REC;
                    end else begin
                        n_overflow_count = ttlh_pkg::sat_inc(r_overflow_count);
                    end
                end else if (w_in_fire) begin
                    if (r_sample_count == '0) begin
                        n_pct   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_target     = CNT_W'(w_product >> ttlh_pkg::FRAC_W);
                        n_run        = '0;
                        n_iss_idx    = '0;
                        n_iss_coarse = 1'b0;
                        n_iss_done   = 1'b0;
                        n_state      = ST_WALK;
                    end
                end
            end
            ST_REC: begin
                w_req.wr     = 1'b1;
                w_req.coarse = r_rec_coarse;
                w_req.idx    = r_rec_idx;
                w_req.wdata  = ttlh_pkg::sat_inc(w_rdata);
                n_state      = ST_IDLE;
            end
            ST_WALK: begin
                // issue the next bin read while the previous one is summed
                w_req.coarse = r_iss_coarse;
                w_req.idx    = r_iss_idx;
                if (!r_iss_done) begin
                    n_pend_valid = 1'b1;
                    if (!r_iss_coarse && r_iss_idx == IDX_W'(ttlh_pkg::FINE_BUCKETS - 1)) begin
                        n_iss_coarse = 1'b1;
                        n_iss_idx    = '0;
                    end else if (r_iss_coarse &&
                                 r_iss_idx == IDX_W'(ttlh_pkg::COARSE_BUCKETS - 1)) begin
                        n_iss_done = 1'b1;
                    end else begin
                        n_iss_idx = r_iss_idx + IDX_W'(1);
                    end
                end
                if (r_pend_valid) begin
                    n_run = w_run_sum;
                end
                if (w_hit) begin
                    n_pct        = r_pend_coarse ? PCT_W'(w_coarse_bound) : PCT_W'(r_pend_idx);
                    n_pend_valid = 1'b0;
                    n_state      = ST_DONE;
                end else if (r_pend_valid && w_last) begin
                    n_pct        = PCT_W'(ttlh_pkg::COARSE_END);
                    n_pend_valid = 1'b0;
                    n_state      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_pct    = r_pct;
                    n_out_sample = r_sample_count;
                    n_out_sum    = r_latency_sum;
                    n_out_ovf    = r_overflow_count;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_CLEAR;
            r_sample_count   <= '0;
            r_latency_sum    <= '0;
            r_overflow_count <= '0;
            r_pend_valid     <= 1'b0;
            r_iss_done       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_sample_count   <= n_sample_count;
            r_latency_sum    <= n_latency_sum;
            r_overflow_count <= n_overflow_count;
            r_pend_valid     <= n_pend_valid;
            r_iss_done       <= n_iss_done;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec_coarse  <= n_rec_coarse;
        r_rec_idx     <= n_rec_idx;
        r_target      <= n_target;
        r_run         <= n_run;
        r_iss_idx     <= n_iss_idx;
        r_iss_coarse  <= n_iss_coarse;
        r_pend_coarse <= n_pend_coarse;
        r_pend_idx    <= n_pend_idx;
        r_pct         <= n_pct;
        r_out_pct     <= n_out_pct;
        r_out_sample  <= n_out_sample;
        r_out_sum     <= n_out_sum;
        r_out_ovf     <= n_out_ovf;
    end

`ifndef ASSERT_OFF
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> !w_clr_busy)
        else $error("bin store still clearing outside the clear state");

    a_rec_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_item.func == ttlh_pkg::FUNC_RECORD && (w_is_fine || w_is_coarse))
        |=> (r_state == ST_REC))
        else $error("binned record did not enter write-back");

    a_walk_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_run <= RUN_W'(r_target)))
        else $error("walk kept going past the target");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded without a finished query");
`endif

endmodule
